// ----- rtl/pixel_twinkle_fade_engine_core_assert.svh -----
// Assertion macros for the twinkle/fade engine checker.
// Expects clk_i and rst_ni in the scope of the use.
`ifndef PIXEL_TWINKLE_FADE_ENGINE_CORE_ASSERT_SVH
`define PIXEL_TWINKLE_FADE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define TFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tfe_pkg.sv -----
// Shared types, codes and the per-tick pixel update for the twinkle/fade engine.
// No dependencies.
package tfe_pkg;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_ADD  = 2'd1,
    FN_TICK = 2'd2
  } tfe_func_e;

  typedef enum logic [2:0] {
    STS_UPDATED   = 3'd0,
    STS_REMOVED   = 3'd1,
    STS_ADDED     = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_FULL      = 3'd4,
    STS_LOADED    = 3'd5,
    STS_EMPTY     = 3'd6
  } tfe_status_e;

  typedef enum logic [1:0] {
    PH_UP   = 2'd0,
    PH_DOWN = 2'd1,
    PH_NORM = 2'd2
  } tfe_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD_RD,
    ST_ADD_OUT,
    ST_EMPTY,
    ST_TICK_RD,
    ST_TICK_WB
  } tfe_state_e;

  localparam logic [2:0] REG_NORMAL_BRIGHT = 3'd0;
  localparam logic [2:0] REG_MAX_ACTIVE    = 3'd1;
  localparam logic [2:0] REG_HUE_WHEEL_0   = 3'd2;
  localparam logic [2:0] REG_HUE_WHEEL_1   = 3'd3;
  localparam logic [2:0] REG_HUE_WHEEL_2   = 3'd4;
  localparam logic [2:0] REG_HUE_WHEEL_3   = 3'd5;
  localparam logic [2:0] REG_HUE_WHEEL_4   = 3'd6;
  localparam logic [2:0] REG_HUE_WHEEL_5   = 3'd7;

  localparam logic [7:0] NORMAL_BRIGHT_RST = 8'd128;
  localparam logic [4:0] MAX_ACTIVE_RST    = 5'd16;
  localparam logic [7:0] HUE_WHEEL_RST [6] = '{8'd0, 8'd64, 8'd160, 8'd96, 8'd192, 8'd32};
  localparam logic [2:0] PICK_LAST         = 3'd5;

  localparam logic [7:0] CH_MAX      = 8'd255;
  localparam logic [7:0] UP_SAT_STEP = 8'd2;
  localparam logic [7:0] UP_VAL_STEP = 8'd1;
  localparam logic [7:0] DOWN_STEP   = 8'd4;

  typedef struct packed {
    logic ins;
    logic wr;
    logic fin;
  } tfe_tbl_cmd_t;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    tfe_phase_e phase;
    logic       gone;
  } tfe_step_t;

  function automatic tfe_step_t tfe_tick_step(logic [23:0] hsv, tfe_phase_e ph,
                                              logic [7:0] pick_hue, logic [7:0] normal);
    tfe_step_t r;
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    h = hsv[23:16];
    s = hsv[15:8];
    v = hsv[7:0];
    r.h = h;
    r.s = s;
    r.v = v;
    r.phase = ph;
    r.gone = 1'b0;
    unique case (ph)
      PH_DOWN: begin
        if (v == 8'd0 && s == CH_MAX) begin
          r.h = pick_hue;
          r.s = CH_MAX;
          r.v = 8'd0;
          r.phase = PH_NORM;
        end else begin
          r.v = (v <= DOWN_STEP) ? 8'd0 : v - DOWN_STEP;
          r.s = (s >= CH_MAX - DOWN_STEP) ? CH_MAX : s + DOWN_STEP;
        end
      end
      PH_NORM: begin
        if ({1'b0, v} + 9'd1 >= {1'b0, normal}) begin
          r.v = normal;
          r.gone = 1'b1;
        end else begin
          r.v = v + 8'd1;
        end
      end
      default: begin
        if (v == CH_MAX && s == 8'd0) begin
          r.phase = PH_DOWN;
        end else begin
          r.v = (v == CH_MAX) ? CH_MAX : v + UP_VAL_STEP;
          r.s = (s <= UP_SAT_STEP) ? 8'd0 : s - UP_SAT_STEP;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tfe_ram.sv -----
// Generic single-clock RAM, one write port, one read port, registered read data.
// No dependencies.
module tfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tfe_table.sv -----
// Sorted table of active pixels with phases: parallel lookup, sorted insert,
// in-place compacting write-back during a tick. Depends on tfe_pkg.
module tfe_table #(
  parameter int PIX_W = 8,
  parameter int SLOTS = 16,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tfe_pkg::tfe_tbl_cmd_t cmd_i,
  input  logic [PIX_W-1:0]     px_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [PIX_W-1:0]     wr_px_i,
  input  tfe_pkg::tfe_phase_e  wr_phase_i,
  input  logic [CNT_W-1:0]     fin_cnt_i,
  output logic [CNT_W-1:0]     count_o,
  output logic                 dup_o,
  output logic [PIX_W-1:0]     rd_px_o,
  output tfe_pkg::tfe_phase_e  rd_phase_o
);

  logic [PIX_W-1:0]    px_q [SLOTS];
  tfe_pkg::tfe_phase_e ph_q [SLOTS];
  logic [CNT_W-1:0]    cnt_q;
  logic [SLOTS-1:0]    lt;
  logic [SLOTS-1:0]    eq;

  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    logic                valid;
    logic                prev_lt;
    logic [PIX_W-1:0]    prev_px;
    tfe_pkg::tfe_phase_e prev_ph;

    assign valid = CNT_W'(i) < cnt_q;
    assign lt[i] = valid && (px_q[i] < px_i);
    assign eq[i] = valid && (px_q[i] == px_i);

    if (i == 0) begin : g_first
      assign prev_lt = 1'b1;
      assign prev_px = px_i;
      assign prev_ph = tfe_pkg::PH_UP;
    end else begin : g_rest
      assign prev_lt = lt[i-1];
      assign prev_px = px_q[i-1];
      assign prev_ph = ph_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins && CNT_W'(i) <= cnt_q) begin
        if (!lt[i]) begin
          if (prev_lt) begin
            px_q[i] <= px_i;
            ph_q[i] <= tfe_pkg::PH_UP;
          end else begin
            px_q[i] <= prev_px;
            ph_q[i] <= prev_ph;
          end
        end
      end else if (cmd_i.wr && wr_idx_i == IDX_W'(i)) begin
        px_q[i] <= wr_px_i;
        ph_q[i] <= wr_phase_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.ins) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.fin) begin
      cnt_q <= fin_cnt_i;
    end
  end

  assign count_o    = cnt_q;
  assign dup_o      = |eq;
  assign rd_px_o    = px_q[rd_idx_i];
  assign rd_phase_o = ph_q[rd_idx_i];

endmodule

// ----- rtl/pixel_twinkle_fade_engine_core.sv -----
// Twinkle/fade engine: an HSV pixel store in a synchronous RAM and a sorted table of up to
// ACTIVE_SLOTS active pixels, one transaction at a time. A tick takes each active entry
// through one pixel-store read, then the update and write-back through the single RAM
// port pair; a result waits in the output register while the next transaction is taken.
// The pixel store has no reset and needs no clearing pass.
// Depends on tfe_pkg, tfe_ram, tfe_table.
module pixel_twinkle_fade_engine_core #(
  parameter int PIXEL_COUNT  = 256,
  parameter int ACTIVE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // func[1:0], pixel_index[9:2], hue_pick[12:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[2:0], pixel_index_res[10:3], hue[18:11],
                                      // sat[26:19], val[34:27]
  output logic        m_axis_tlast
);

  localparam int PIX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int CNT_W = $clog2(ACTIVE_SLOTS + 1);
  localparam int IDX_W = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam logic [7:0] SLOTS_8 = 8'(ACTIVE_SLOTS);

  // configuration
  logic [7:0] normal_bright_q;
  logic [4:0] max_active_q;
  logic [7:0] hue_wheel_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_bright_q <= tfe_pkg::NORMAL_BRIGHT_RST;
      max_active_q    <= tfe_pkg::MAX_ACTIVE_RST;
      for (int k = 0; k < 6; k++) begin
        hue_wheel_q[k] <= tfe_pkg::HUE_WHEEL_RST[k];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfe_pkg::REG_NORMAL_BRIGHT: normal_bright_q <= cfg_data_i;
        tfe_pkg::REG_MAX_ACTIVE:    max_active_q    <= cfg_data_i[4:0];
        tfe_pkg::REG_HUE_WHEEL_0:   hue_wheel_q[0]  <= cfg_data_i;
        tfe_pkg::REG_HUE_WHEEL_1:   hue_wheel_q[1]  <= cfg_data_i;
        tfe_pkg::REG_HUE_WHEEL_2:   hue_wheel_q[2]  <= cfg_data_i;
        tfe_pkg::REG_HUE_WHEEL_3:   hue_wheel_q[3]  <= cfg_data_i;
        tfe_pkg::REG_HUE_WHEEL_4:   hue_wheel_q[4]  <= cfg_data_i;
        tfe_pkg::REG_HUE_WHEEL_5:   hue_wheel_q[5]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input decode
  logic [1:0]       in_func;
  logic [7:0]       in_pix;
  logic [2:0]       in_pick;
  logic [2:0]       pick_sat;
  logic [7:0]       wheel_hue;
  logic [PIX_W-1:0] pix_mod [256];
  logic             acc;

  assign in_func   = s_axis_tdata[1:0];
  assign in_pix    = s_axis_tdata[9:2];
  assign in_pick   = s_axis_tdata[12:10];
  assign pick_sat  = (in_pick > tfe_pkg::PICK_LAST) ? tfe_pkg::PICK_LAST : in_pick;
  assign wheel_hue = hue_wheel_q[pick_sat];

  for (genvar k = 0; k < 256; k++) begin : g_pix_mod
    assign pix_mod[k] = PIX_W'(k % PIXEL_COUNT);
  end

  // sequencer state
  tfe_pkg::tfe_state_e state_q, state_d;
  logic [PIX_W-1:0]    px_q;
  logic [7:0]          pick_hue_q;
  logic [CNT_W-1:0]    ti_q, ti_d;
  logic [CNT_W-1:0]    tj_q, tj_d;

  assign s_axis_tready = (state_q == tfe_pkg::ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // pixel store
  logic             ram_we;
  logic             ram_re;
  logic [PIX_W-1:0] ram_waddr;
  logic [PIX_W-1:0] ram_raddr;
  logic [23:0]      ram_wdata;
  logic [23:0]      ram_rdata;

  tfe_ram #(
    .WIDTH(24),
    .DEPTH(PIXEL_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // active table
  tfe_pkg::tfe_tbl_cmd_t tbl_cmd;
  tfe_pkg::tfe_phase_e   tbl_rd_phase;
  logic [PIX_W-1:0]      tbl_rd_px;
  logic [CNT_W-1:0]      tbl_count;
  logic [CNT_W-1:0]      fin_cnt;
  logic                  tbl_dup;
  tfe_pkg::tfe_step_t    step;

  tfe_table #(
    .PIX_W(PIX_W),
    .SLOTS(ACTIVE_SLOTS),
    .CNT_W(CNT_W),
    .IDX_W(IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .px_i      (px_q),
    .rd_idx_i  (ti_q[IDX_W-1:0]),
    .wr_idx_i  (tj_q[IDX_W-1:0]),
    .wr_px_i   (tbl_rd_px),
    .wr_phase_i(step.phase),
    .fin_cnt_i (fin_cnt),
    .count_o   (tbl_count),
    .dup_o     (tbl_dup),
    .rd_px_o   (tbl_rd_px),
    .rd_phase_o(tbl_rd_phase)
  );

  assign step = tfe_pkg::tfe_tick_step(ram_rdata, tbl_rd_phase, pick_hue_q, normal_bright_q);

  logic full;
  assign full = (8'(tbl_count) >= SLOTS_8) || (8'(tbl_count) >= {3'b000, max_active_q});

  // output register
  logic                  out_valid_q;
  tfe_pkg::tfe_status_e  out_status_q, out_status_d;
  logic [7:0]            out_px_q, out_px_d;
  logic [23:0]           out_hsv_q, out_hsv_d;
  logic                  out_last_q, out_last_d;
  logic                  out_ld;
  logic                  out_free;
  logic [PIX_W-1:0]      out_px_sel;
  logic [PIX_W+7:0]      out_px_ext;
  logic [CNT_W-1:0]      ti_nx;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign out_px_ext = {8'd0, out_px_sel};
  assign out_px_d   = out_px_ext[7:0];
  assign ti_nx      = ti_q + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    ti_d         = ti_q;
    tj_d         = tj_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = px_q;
    ram_raddr    = px_q;
    ram_wdata    = {pick_hue_q, tfe_pkg::CH_MAX, normal_bright_q};
    tbl_cmd      = '0;
    fin_cnt      = tj_q;
    out_ld       = 1'b0;
    out_status_d = tfe_pkg::STS_UPDATED;
    out_px_sel   = px_q;
    out_hsv_d    = ram_rdata;
    out_last_d   = 1'b1;
    unique case (state_q)
      tfe_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_func)
            tfe_pkg::FN_LOAD: state_d = tfe_pkg::ST_LOAD;
            tfe_pkg::FN_ADD:  state_d = tfe_pkg::ST_ADD_RD;
            tfe_pkg::FN_TICK: begin
              ti_d    = '0;
              tj_d    = '0;
              state_d = (tbl_count == '0) ? tfe_pkg::ST_EMPTY : tfe_pkg::ST_TICK_RD;
            end
            default: ;
          endcase
        end
      end
      tfe_pkg::ST_LOAD: begin
        if (out_free) begin
          ram_we       = 1'b1;
          out_ld       = 1'b1;
          out_status_d = tfe_pkg::STS_LOADED;
          out_hsv_d    = ram_wdata;
          state_d      = tfe_pkg::ST_IDLE;
        end
      end
      tfe_pkg::ST_ADD_RD: begin
        ram_re  = 1'b1;
        state_d = tfe_pkg::ST_ADD_OUT;
      end
      tfe_pkg::ST_ADD_OUT: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (full) begin
            out_status_d = tfe_pkg::STS_FULL;
          end else if (tbl_dup) begin
            out_status_d = tfe_pkg::STS_DUPLICATE;
          end else begin
            out_status_d = tfe_pkg::STS_ADDED;
            tbl_cmd.ins  = 1'b1;
          end
          state_d = tfe_pkg::ST_IDLE;
        end
      end
      tfe_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_status_d = tfe_pkg::STS_EMPTY;
          out_px_sel   = '0;
          out_hsv_d    = '0;
          state_d      = tfe_pkg::ST_IDLE;
        end
      end
      tfe_pkg::ST_TICK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tbl_rd_px;
        state_d   = tfe_pkg::ST_TICK_WB;
      end
      tfe_pkg::ST_TICK_WB: begin
        out_px_sel = tbl_rd_px;
        if (out_free) begin
          ram_we       = 1'b1;
          ram_waddr    = tbl_rd_px;
          ram_wdata    = {step.h, step.s, step.v};
          out_ld       = 1'b1;
          out_status_d = step.gone ? tfe_pkg::STS_REMOVED : tfe_pkg::STS_UPDATED;
          out_hsv_d    = {step.h, step.s, step.v};
          out_last_d   = (ti_nx == tbl_count);
          ti_d         = ti_nx;
          if (!step.gone) begin
            tbl_cmd.wr = 1'b1;
            tj_d       = tj_q + CNT_W'(1);
          end
          fin_cnt = tj_d;
          if (out_last_d) begin
            tbl_cmd.fin = 1'b1;
            state_d     = tfe_pkg::ST_IDLE;
          end else begin
            state_d = tfe_pkg::ST_TICK_RD;
          end
        end
      end
      default: state_d = tfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfe_pkg::ST_IDLE;
      ti_q        <= '0;
      tj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q       <= pix_mod[in_pix];
      pick_hue_q <= wheel_hue;
    end
    if (out_ld) begin
      out_status_q <= out_status_d;
      out_px_q     <= out_px_d;
      out_hsv_q    <= out_hsv_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_hsv_q[7:0], out_hsv_q[15:8], out_hsv_q[23:16],
                          out_px_q, out_status_q};

endmodule

// ----- rtl/tfe_chk.sv -----
// Port-level checker for the twinkle/fade engine, bound to the top level.
// Depends on tfe_pkg and pixel_twinkle_fade_engine_core_assert.svh.
`include "pixel_twinkle_fade_engine_core_assert.svh"

module tfe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `TFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  `TFE_ASSERT_NOW(a_empty_res, m_axis_tvalid && m_axis_tdata[2:0] == tfe_pkg::STS_EMPTY, m_axis_tlast && m_axis_tdata[34:3] == 32'd0, "empty-table result malformed")

  `TFE_ASSERT_NOW(a_single_last, m_axis_tvalid && (m_axis_tdata[2:0] == tfe_pkg::STS_LOADED || m_axis_tdata[2:0] == tfe_pkg::STS_ADDED || m_axis_tdata[2:0] == tfe_pkg::STS_DUPLICATE || m_axis_tdata[2:0] == tfe_pkg::STS_FULL), m_axis_tlast, "single-result transaction without last")

  `TFE_ASSERT_NEXT(a_busy_after_acc, s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != 2'd3, !s_axis_tready, "input taken while a transaction is in progress")

  `TFE_ASSERT_NOW(a_load_sat, m_axis_tvalid && m_axis_tdata[2:0] == tfe_pkg::STS_LOADED, m_axis_tdata[26:19] == tfe_pkg::CH_MAX, "loaded pixel not at full saturation")

endmodule

bind pixel_twinkle_fade_engine_core tfe_chk u_tfe_chk (.*);
